[src/string_from_z_function_top_defines.svh]
// Assertion macros for the z-function string builder.
// Included by the top level; no other dependencies.
// Clock and reset are taken from the including module's ports.
`ifndef STRING_FROM_Z_FUNCTION_TOP_DEFINES_SVH
`define STRING_FROM_Z_FUNCTION_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define SFZ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define SFZ_ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define SFZ_ASSERT(lbl, prop, msg)
`define SFZ_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

[src/sfz_pkg.sv]
// Shared constants for the z-function string builder.
// No dependencies.
package sfz_pkg;

   localparam int Z_W         = 11;
   localparam int LETTER_W    = 8;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 8;
   localparam logic [LETTER_W-1:0] FIRST_LETTER_RST = 8'd97;

endpackage

[src/string_from_z_function_top.sv]
// String reconstruction from a z-function, one position per word.
// Uses sfz_pkg and the assertion macros in string_from_z_function_top_defines.svh.
//
// Each word carries the z value at the next position; one result word comes back
// with the letter at that position. A word first fills the prefix entries it newly
// covers (at most MAX_LEN per string in total) and reads its prefix value; it then
// copies an earlier letter when that value is positive, or walks the prefix chain
// and picks the lowest free letter when it is zero. A word at position 0 or past
// the end of the store goes straight to its result.
// The prefix memory needs no clearing pass: a fill mark tracks how far the current
// string has written it, and each entry is written before it is read. A new word is
// taken while the previous result still waits on the response side; the next
// result then holds in the last step until that one is taken.
`include "string_from_z_function_top_defines.svh"

module string_from_z_function_top #(
   parameter int MAX_LEN       = 1024,
   parameter int ALPHABET_SIZE = 26
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [sfz_pkg::LETTER_W-1:0]    csr_wr_data,   // first_letter
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sfz_pkg::REQ_TDATA_W-1:0] req_tdata,     // [10:0] z_value, rest zero
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sfz_pkg::RSP_TDATA_W-1:0] rsp_tdata,     // [7:0] letter
   output logic                            rsp_tuser,     // [0] no_free_letter
   output logic                            rsp_tlast
);

   localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int PW  = $clog2(MAX_LEN + 1);
   localparam int ZW  = sfz_pkg::Z_W;
   localparam int SW  = ((PW > ZW) ? PW : ZW) + 1;
   localparam int AS  = ALPHABET_SIZE;
   localparam int LW  = $clog2(ALPHABET_SIZE);
   localparam int CW  = sfz_pkg::LETTER_W;

   typedef enum logic [3:0] {
      S_IDLE, S_FILL, S_PREAD, S_PWAIT, S_KREAD, S_CHAIN, S_COPY, S_PICK, S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [PW-1:0]    hi_ff, hi_in;
   logic [PW-1:0]    fill_idx_ff, fill_idx_in;
   logic [PW-1:0]    fill_end_ff, fill_end_in;
   logic             last_ff, last_in;
   logic [AS-1:0]    used_ff, used_in;
   logic [LW-1:0]    offset_ff, offset_in;
   logic             ok_ff, ok_in;
   logic [CW-1:0]    first_letter_ff, first_letter_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic [CW-1:0]    rsp_letter_ff, rsp_letter_in;
   logic             rsp_nofree_ff, rsp_nofree_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [AW-1:0]    prefix_mem [MAX_LEN];
   logic [LW-1:0]    letter_mem [MAX_LEN];
   logic             pm_we;
   logic [AW-1:0]    pm_waddr, pm_raddr;
   logic [AW-1:0]    pm_wdata;
   logic [AW-1:0]    pm_rd_ff;
   logic             lm_we;
   logic [AW-1:0]    lm_waddr, lm_raddr;
   logic [LW-1:0]    lm_wdata;
   logic [LW-1:0]    lm_rd_ff;

   logic             req_accept;
   logic             out_free;
   logic [SW-1:0]    reach;
   logic [PW-1:0]    fill_start;
   logic [PW-1:0]    pos_next;
   logic [PW-1:0]    hi_cand;

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_letter_ff;
   assign rsp_tuser  = rsp_nofree_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      reach = SW'(pos_ff) + SW'(req_tdata[ZW-1:0]);
      if (reach > SW'(MAX_LEN)) begin
         reach = SW'(MAX_LEN);
      end
      fill_start = (hi_ff > pos_ff) ? hi_ff : pos_ff;
      pos_next   = pos_ff + PW'(1);
      hi_cand    = (fill_idx_ff > pos_next) ? fill_idx_ff : pos_next;
   end

   always_comb begin
      state_in        = state_ff;
      pos_in          = pos_ff;
      hi_in           = hi_ff;
      fill_idx_in     = fill_idx_ff;
      fill_end_in     = fill_end_ff;
      last_in         = last_ff;
      used_in         = used_ff;
      offset_in       = offset_ff;
      ok_in           = ok_ff;
      first_letter_in = csr_wr_en ? csr_wr_data : first_letter_ff;
      rsp_tvalid_in   = rsp_tvalid_ff && !rsp_tready;
      rsp_letter_in   = rsp_letter_ff;
      rsp_nofree_in   = rsp_nofree_ff;
      rsp_last_in     = rsp_last_ff;
      pm_we           = 1'b0;
      pm_waddr        = pos_ff[AW-1:0];
      pm_wdata        = '0;
      pm_raddr        = pos_ff[AW-1:0];
      lm_we           = 1'b0;
      lm_waddr        = pos_ff[AW-1:0];
      lm_wdata        = offset_ff;
      lm_raddr        = pm_rd_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               last_in = req_tlast;
               priority if (pos_ff == PW'(MAX_LEN)) begin
                  ok_in     = 1'b0;
                  offset_in = '0;
                  state_in  = S_DONE;
               end else if (pos_ff == '0) begin
                  pm_we     = 1'b1;
                  pm_waddr  = '0;
                  pm_wdata  = '0;
                  hi_in     = PW'(1);
                  ok_in     = 1'b1;
                  offset_in = '0;
                  state_in  = S_DONE;
               end else begin
                  fill_idx_in = fill_start;
                  fill_end_in = PW'(reach);
                  state_in    = S_FILL;
               end
            end
         end
         S_FILL: begin
            if (fill_idx_ff < fill_end_ff) begin
               pm_we       = 1'b1;
               pm_waddr    = fill_idx_ff[AW-1:0];
               pm_wdata    = AW'(fill_idx_ff - pos_ff + PW'(1));
               fill_idx_in = fill_idx_ff + PW'(1);
            end else begin
               if (hi_ff <= pos_ff && fill_idx_ff == pos_ff) begin
                  pm_we    = 1'b1;
                  pm_waddr = pos_ff[AW-1:0];
                  pm_wdata = '0;
               end
               hi_in    = (hi_ff > hi_cand) ? hi_ff : hi_cand;
               state_in = S_PREAD;
            end
         end
         S_PREAD: begin
            pm_raddr = pos_ff[AW-1:0];
            state_in = S_PWAIT;
         end
         S_PWAIT: begin
            if (pm_rd_ff != '0) begin
               lm_raddr = pm_rd_ff - AW'(1);
               state_in = S_COPY;
            end else begin
               pm_raddr = AW'(pos_ff - PW'(1));
               used_in  = AS'(1);
               state_in = S_KREAD;
            end
         end
         S_COPY: begin
            offset_in = lm_rd_ff;
            ok_in     = 1'b1;
            state_in  = S_DONE;
         end
         S_KREAD, S_CHAIN: begin
            if (state_ff == S_CHAIN) begin
               used_in = used_ff | (AS'(1) << lm_rd_ff);
            end
            if (pm_rd_ff != '0) begin
               lm_raddr = pm_rd_ff;
               pm_raddr = pm_rd_ff - AW'(1);
               state_in = S_CHAIN;
            end else begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            ok_in     = !(&used_ff);
            offset_in = '0;
            for (int j = AS - 1; j >= 0; j--) begin
               if (!used_ff[j]) begin
                  offset_in = LW'(j);
               end
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               if (pos_ff != PW'(MAX_LEN)) begin
                  lm_we    = 1'b1;
                  lm_waddr = pos_ff[AW-1:0];
                  lm_wdata = offset_ff;
               end
               rsp_tvalid_in = 1'b1;
               rsp_letter_in = ok_ff ? (first_letter_ff + CW'(offset_ff)) : '0;
               rsp_nofree_in = !ok_ff;
               rsp_last_in   = last_ff;
               priority if (last_ff) begin
                  pos_in = '0;
               end else if (pos_ff != PW'(MAX_LEN)) begin
                  pos_in = pos_next;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pm_we) begin
         prefix_mem[pm_waddr] <= pm_wdata;
      end
      pm_rd_ff <= prefix_mem[pm_raddr];
   end

   always_ff @(posedge clock) begin
      if (lm_we) begin
         letter_mem[lm_waddr] <= lm_wdata;
      end
      lm_rd_ff <= letter_mem[lm_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         pos_ff          <= '0;
         hi_ff           <= '0;
         first_letter_ff <= sfz_pkg::FIRST_LETTER_RST;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         pos_ff          <= pos_in;
         hi_ff           <= hi_in;
         first_letter_ff <= first_letter_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
      end
      fill_idx_ff   <= fill_idx_in;
      fill_end_ff   <= fill_end_in;
      last_ff       <= last_in;
      used_ff       <= used_in;
      offset_ff     <= offset_in;
      ok_ff         <= ok_in;
      rsp_letter_ff <= rsp_letter_in;
      rsp_nofree_ff <= rsp_nofree_in;
      rsp_last_ff   <= rsp_last_in;
   end

   `SFZ_ASSERT(a_bounds, (pos_ff <= PW'(MAX_LEN)) && (hi_ff <= PW'(MAX_LEN)), "position or fill mark out of range")
   `SFZ_ASSERT(a_mark_covers_pos, (state_ff == S_PWAIT) |-> (hi_ff > pos_ff), "fill mark below current position")
   `SFZ_ASSERT(a_copy_src, (state_ff == S_PWAIT && pm_rd_ff != '0) |-> (PW'(pm_rd_ff) <= pos_ff), "copy source past position")
   `SFZ_ASSERT(a_chain_down, (state_ff == S_KREAD || state_ff == S_CHAIN) |-> (PW'(pm_rd_ff) < pos_ff), "prefix chain does not descend")
   `SFZ_ASSERT_NEVER(a_fill_low, state_ff == S_FILL && pm_we && PW'(pm_waddr) < pos_ff, "fill write below position")

endmodule

[verif/string_from_z_function_top_tb.sv]
// Self-checking testbench for string_from_z_function_top: feeds z-function words,
// predicts each letter word in a local model and compares it field by field.
// Depends on sfz_pkg and the RTL top level only.
`timescale 1ns / 100ps

module string_from_z_function_top_tb;

   localparam int STORE_DEPTH = 1024;
   localparam int ALPHA_SIZE  = 26;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int ZW          = sfz_pkg::Z_W;
   localparam int CW          = sfz_pkg::LETTER_W;

   typedef struct packed {
      logic [CW-1:0] letter;
      logic          no_free;
      logic          last;
   } letter_word_type;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            csr_wr_en   = 1'b0;
   logic [CW-1:0]                   csr_wr_data = '0;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [sfz_pkg::REQ_TDATA_W-1:0] req_tdata   = '0;   // [10:0] z_value, rest zero
   logic                            req_tlast   = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [sfz_pkg::RSP_TDATA_W-1:0] rsp_tdata;          // [7:0] letter
   logic                            rsp_tuser;          // [0] no_free_letter
   logic                            rsp_tlast;

   logic [ZW-1:0]       pfx_mem [0:STORE_DEPTH-1];
   logic [4:0]          ltr_mem [0:STORE_DEPTH-1];
   int unsigned         cur_pos       = 0;
   logic [CW-1:0]       first_letter_q = sfz_pkg::FIRST_LETTER_RST;
   letter_word_type     pending_letters[$];

   int          chars [0:1099];
   int unsigned zvals [0:1099];
   int          z_list[$];
   logic        steady      = 1'b0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   string_from_z_function_top #(
      .MAX_LEN       (STORE_DEPTH),
      .ALPHABET_SIZE (ALPHA_SIZE)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 96)
         return $urandom_range(4, 12);
      return $urandom_range(13, 40);
   endfunction

   task automatic predict_letter(input logic [ZW-1:0] z, input logic last);
      int unsigned     room, d, k, offset, j;
      logic [31:0]     banned;
      logic            found;
      letter_word_type want;
      offset = 0;
      found  = 1'b1;
      if (cur_pos >= STORE_DEPTH) begin
         found = 1'b0;
      end else if (cur_pos == 0) begin
         for (j = 0; j < STORE_DEPTH; j++)
            pfx_mem[j] = '0;
         ltr_mem[0] = '0;
      end else begin
         room = STORE_DEPTH - cur_pos;
         d = (z > room) ? room : z;
         while (d > 0 && pfx_mem[cur_pos + d - 1] == 0) begin
            pfx_mem[cur_pos + d - 1] = ZW'(d);
            d--;
         end
         if (pfx_mem[cur_pos] != 0) begin
            offset = ltr_mem[pfx_mem[cur_pos] - 1];
         end else begin
            banned = 32'd1;
            k = pfx_mem[cur_pos - 1];
            while (k > 0 && k < STORE_DEPTH) begin
               banned[ltr_mem[k]] = 1'b1;
               k = pfx_mem[k - 1];
            end
            found = 1'b0;
            for (j = 0; j < ALPHA_SIZE && !found; j++)
               if (!banned[j]) begin
                  offset = j;
                  found  = 1'b1;
               end
         end
         ltr_mem[cur_pos] = 5'(offset);
      end
      want.letter  = found ? CW'(first_letter_q + offset) : '0;
      want.no_free = !found;
      want.last    = last;
      pending_letters = {pending_letters, want};
      if (last)
         cur_pos = 0;
      else if (cur_pos < STORE_DEPTH)
         cur_pos++;
   endtask

   always @(posedge clock) begin : check_letters
      letter_word_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_letters.size() == 0) begin
            $error("unexpected letter word: letter %0d", rsp_tdata);
            error_count++;
         end else begin
            want = pending_letters.pop_front();
            if (rsp_tdata !== want.letter) begin
               $error("letter: expected %0d, got %0d", want.letter, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== want.no_free) begin
               $error("no_free_letter: expected %0d, got %0d", want.no_free, rsp_tuser);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_out: expected %0d, got %0d", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (1 + idle_len()) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_position(input logic [ZW-1:0] z, input logic last);
      logic [sfz_pkg::REQ_TDATA_W-1:0] word;
      int unsigned                     gap;
      gap = steady ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      word         = '0;
      word[ZW-1:0] = z;
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tlast  <= last;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      predict_letter(z, last);
   endtask

   task automatic drain_letters();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_letters.size() != 0) @(posedge clock);
   endtask

   task automatic set_first_letter(input logic [CW-1:0] value);
      drain_letters();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en      <= 1'b0;
      first_letter_q = value;
   endtask

   task automatic send_z_list();
      logic [ZW-1:0] z;
      int            i;
      for (i = 0; i < z_list.size(); i++) begin
         z = ZW'(z_list[i]);
         send_position(z, i == z_list.size() - 1);
      end
   endtask

   task automatic compute_z(input int unsigned len);
      int unsigned lo, hi, i, n;
      zvals[0] = len;
      lo = 0;
      hi = 0;
      for (i = 1; i < len; i++) begin
         n = 0;
         if (i < hi)
            n = (hi - i < zvals[i - lo]) ? hi - i : zvals[i - lo];
         while (i + n < len && chars[n] == chars[i + n])
            n++;
         if (i + n > hi) begin
            lo = i;
            hi = i + n;
         end
         zvals[i] = n;
      end
   endtask

   task automatic send_text(input int unsigned len, input logic noisy);
      logic [ZW-1:0] z;
      int unsigned   i;
      compute_z(len);
      for (i = 0; i < len; i++) begin
         z = ZW'(zvals[i]);
         if (i == 0 && $urandom_range(0, 1) == 0)
            z = ZW'($urandom_range(0, 2047));
         if (noisy && $urandom_range(0, 7) == 0)
            z = ZW'($urandom_range(0, len + 2));
         send_position(z, i == len - 1);
      end
   endtask

   task automatic test_reset_letter();
      z_list = '{2047, 0, 1, 0, 3, 0, 1, 0};
      send_z_list();
      z_list = '{0};
      send_z_list();
      z_list = '{2, 0};
      send_z_list();
   endtask

   task automatic test_store_clipping();
      z_list = '{1024, 2047, 0, 5};
      send_z_list();
      z_list = '{0, 1024, 1};
      send_z_list();
   endtask

   task automatic test_letter_wrap();
      set_first_letter(8'd255);
      z_list = '{4, 0, 2, 0};
      send_z_list();
      set_first_letter(8'd0);
      z_list = '{0, 0, 0};
      send_z_list();
   endtask

   task automatic test_random_strings(input int unsigned target);
      int unsigned sent, len, alpha, period, r, strings, i;
      sent    = 0;
      strings = 0;
      while (sent < target) begin
         r = $urandom_range(0, 99);
         len = (r < 85) ? $urandom_range(1, 24) :
               (r < 97) ? $urandom_range(25, 120) : $urandom_range(121, 400);
         r = $urandom_range(0, 99);
         alpha = (r < 40) ? $urandom_range(1, 2) :
                 (r < 80) ? $urandom_range(3, 4) :
                 (r < 92) ? $urandom_range(5, 10) : ALPHA_SIZE;
         period = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : len;
         for (i = 0; i < len; i++) begin
            if (i < period || $urandom_range(0, 19) == 0)
               chars[i] = $urandom_range(0, alpha - 1);
            else
               chars[i] = chars[i - period];
         end
         steady = ($urandom_range(0, 4) == 0);
         send_text(len, $urandom_range(0, 9) == 0);
         sent += len;
         strings++;
         if (strings % 25 == 0)
            set_first_letter(CW'($urandom_range(0, 255)));
      end
      steady = 1'b0;
   endtask

   task automatic test_random_z(input int unsigned target);
      int unsigned   sent, run, r;
      logic [ZW-1:0] z;
      logic          last;
      sent = 0;
      run  = 0;
      while (sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 40)
            z = ZW'($urandom_range(0, run + 1));
         else if (r < 65)
            z = ZW'($urandom_range(0, 3));
         else if (r < 85)
            z = ZW'($urandom_range(0, 2047));
         else if (r < 93)
            z = ZW'(1024);
         else
            z = ZW'(2047);
         last = ($urandom_range(0, 9) == 0) || (sent == target - 1);
         send_position(z, last);
         sent++;
         run = last ? 0 : run + 1;
      end
   endtask

   // ruler sequence: deepest prefix chains, then past the end of the store
   task automatic test_long_string();
      int unsigned i, n, c;
      set_first_letter(8'd250);
      for (i = 0; i < 1030; i++) begin
         n = i + 1;
         c = 0;
         while (n % 2 == 0) begin
            n = n / 2;
            c++;
         end
         chars[i] = c;
      end
      send_text(1030, 1'b0);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_letter();
      test_store_clipping();
      test_letter_wrap();
      test_random_strings(550);
      test_random_z(160);
      test_long_string();
      drain_letters();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_letters.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
